[sv/pose_dead_reckoning_defines.svh]
// ============================================================================
// Pose dead reckoning assertion macros
// Shared helpers for concurrent checks in the pose dead reckoning block.
// ============================================================================
`ifndef POSE_DEAD_RECKONING_DEFINES_SVH
`define POSE_DEAD_RECKONING_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PDR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pose dead reckoning check failed");

// Next-cycle implication, disabled while reset is asserted.
`define PDR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pose dead reckoning check failed");

`endif

[sv/pdr_pkg.sv]
// ============================================================================
// Pose dead reckoning package
// Widths, angle constants, arctangent table and shared types.
// ============================================================================
package pdr_pkg;

    localparam int POS_FRAC_BITS = 16;
    localparam int CORDIC_STAGES = 16;
    localparam int CORDIC_N      = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
    // Register stages in the front end ahead of the CORDIC chain.
    localparam int FR_N          = 7;

    // Displacement width after the interval scaling.
    localparam int DW  = 64 - POS_FRAC_BITS;
    // CORDIC datapath width (Q2.30 plus guard).
    localparam int CW  = 34;
    // Signed reduced angle width.
    localparam int AW  = 36;
    // Angle magnitude width (heading times 64).
    localparam int AMW = 38;
    // Partial product and sum widths.
    localparam int HW  = DW - 24;
    localparam int FW  = DW + CW + 1;
    localparam int MW  = FW - 30;
    localparam int SAT_W = DW + CW - 26;

    localparam logic [AMW-1:0]       TWO_PI_M  = 38'd6746518852;
    localparam logic signed [AW-1:0] TWO_PI_A  = 36'sd6746518852;
    localparam logic signed [AW-1:0] PI_A      = 36'sd3373259426;
    localparam logic signed [AW-1:0] HALF_PI_A = 36'sd1686629713;
    localparam logic signed [CW-1:0] GAIN      = 34'sd652032874;

    localparam logic signed [31:0] S32_MAX = 32'sh7fffffff;
    localparam logic signed [31:0] S32_MIN = 32'sh80000000;

    localparam logic [31:0] ATAN_Q30 [32] = '{
        32'd843314856, 32'd497837829, 32'd263043836, 32'd133525158, 32'd67021686,
        32'd33543515, 32'd16775850, 32'd8388437, 32'd4194282, 32'd2097149,
        32'd1048575, 32'd524287, 32'd262143, 32'd131071, 32'd65535, 32'd32767,
        32'd16383, 32'd8191, 32'd4095, 32'd2047, 32'd1023, 32'd511, 32'd255,
        32'd127, 32'd63, 32'd31, 32'd15, 32'd8, 32'd4, 32'd2, 32'd1, 32'd0
    };

    typedef logic signed [DW-1:0] disp_t;

    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] hd_new;
        logic               hov;
        disp_t              dx;
        disp_t              dy;
        logic               neg;
    } side_t;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
    } cord_t;

    typedef struct packed {
        logic               ovf;
        logic signed [31:0] val;
    } sat_t;

    function automatic sat_t sat32(input logic signed [SAT_W-1:0] v);
        sat_t s;
        s.ovf = ~((&v[SAT_W-1:31]) | ~(|v[SAT_W-1:31]));
        if (s.ovf)
        begin
            s.val = v[SAT_W-1] ? S32_MIN : S32_MAX;
        end
        else
        begin
            s.val = v[31:0];
        end
        return s;
    endfunction

    // One restoring step of the angle reduction by 2^k turns.
    function automatic logic [AMW-1:0] mod_step(input logic [AMW-1:0] m, input int k);
        logic [AMW-1:0] d;
        d = TWO_PI_M << k;
        return (m >= d) ? (m - d) : m;
    endfunction

endpackage

[sv/pdr_cordic.sv]
// ============================================================================
// Pose dead reckoning CORDIC
// Rotation-mode CORDIC, one registered stage per iteration, with sideband.
// ============================================================================
module pdr_cordic
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_vld,
    input  pdr_pkg::side_t in_side,
    input  pdr_pkg::cord_t in_cord,
    output logic           out_vld,
    output pdr_pkg::side_t out_side,
    output pdr_pkg::cord_t out_cord
);

    logic           stg_vld  [pdr_pkg::CORDIC_N+1];
    pdr_pkg::side_t stg_side [pdr_pkg::CORDIC_N+1];
    pdr_pkg::cord_t stg_cord [pdr_pkg::CORDIC_N+1];

    assign stg_vld[0]  = in_vld;
    assign stg_side[0] = in_side;
    assign stg_cord[0] = in_cord;

    for (genvar i = 0; i < pdr_pkg::CORDIC_N; i++)
    begin : g_stage
        logic           vld_reg;
        pdr_pkg::side_t side_reg;
        pdr_pkg::cord_t cord_reg;
        pdr_pkg::cord_t cord_next;
        logic signed [pdr_pkg::CW-1:0] xs;
        logic signed [pdr_pkg::CW-1:0] ys;
        logic signed [pdr_pkg::CW-1:0] at;

        assign xs = stg_cord[i].x >>> i;
        assign ys = stg_cord[i].y >>> i;
        assign at = pdr_pkg::CW'($signed({1'b0, pdr_pkg::ATAN_Q30[i]}));

        always_comb
        begin
            if (!stg_cord[i].z[pdr_pkg::CW-1])
            begin
                cord_next.x = stg_cord[i].x - ys;
                cord_next.y = stg_cord[i].y + xs;
                cord_next.z = stg_cord[i].z - at;
            end
            else
            begin
                cord_next.x = stg_cord[i].x + ys;
                cord_next.y = stg_cord[i].y - xs;
                cord_next.z = stg_cord[i].z + at;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg <= 1'b0;
            end
            else
            begin
                vld_reg <= stg_vld[i];
            end
        end

        always_ff @(posedge clk)
        begin
            side_reg <= stg_side[i];
            cord_reg <= cord_next;
        end

        assign stg_vld[i+1]  = vld_reg;
        assign stg_side[i+1] = side_reg;
        assign stg_cord[i+1] = cord_reg;
    end

    assign out_vld  = stg_vld[pdr_pkg::CORDIC_N];
    assign out_side = stg_side[pdr_pkg::CORDIC_N];
    assign out_cord = stg_cord[pdr_pkg::CORDIC_N];

endmodule

[sv/pose_dead_reckoning.sv]
// ============================================================================
// Pose dead reckoning
// Predicts a planar pose from body-frame velocity over a time interval.
// ============================================================================
//
//   channel   handshake        word
//   input     start / busy     pose_x, pose_y, heading, vel_forward,
//                              vel_lateral, vel_turn, interval
//   result    done (strobe)    new_x, new_y, new_heading, overflow
//
// A word is taken at every clock edge with start high; busy never rises, so
// one pose enters per cycle. Each word produces exactly one result, shown for
// one cycle with done high, once the word has passed the front-end registers,
// the CORDIC stage chain and the back-end registers.
// Reset clears only the valid bits, so words in flight are dropped.
// The receiver cannot stall, so the pipeline advances every cycle.
//
// The front end scales the velocities by the interval, saturates the new
// heading and reduces the heading modulo two pi in restoring steps over
// several stages. The CORDIC chain gives cosine and sine, which are then
// multiplied with the displacements in split partial products, summed with
// the old position and saturated.

`include "pose_dead_reckoning_defines.svh"

module pose_dead_reckoning
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] pose_x,
    input  logic signed [31:0] pose_y,
    input  logic signed [31:0] heading,
    input  logic signed [31:0] vel_forward,
    input  logic signed [31:0] vel_lateral,
    input  logic signed [31:0] vel_turn,
    input  logic        [31:0] interval,
    output logic               done,
    output logic signed [31:0] new_x,
    output logic signed [31:0] new_y,
    output logic signed [31:0] new_heading,
    output logic               overflow
);

    // Front-end stage contents.
    typedef struct packed {
        logic signed [31:0]               px;
        logic signed [31:0]               py;
        logic signed [31:0]               hd;
        pdr_pkg::disp_t                   dx;
        pdr_pkg::disp_t                   dy;
        pdr_pkg::disp_t                   dth;
        logic signed [31:0]               hd_new;
        logic                             hov;
        logic [pdr_pkg::AMW-1:0]          amag;
        logic                             asgn;
        logic signed [pdr_pkg::AW-1:0]    r;
        logic                             neg;
    } front_t;

    assign busy = 1'b0;

    // ------------------------------------------------------------------
    // Front end: scaling, heading update and angle reduction.
    // ------------------------------------------------------------------
    logic   fr_vld_reg [pdr_pkg::FR_N];
    front_t fr_reg     [pdr_pkg::FR_N];
    front_t fr_next    [pdr_pkg::FR_N];

    logic signed [64:0]             prod_f;
    logic signed [64:0]             prod_l;
    logic signed [64:0]             prod_t;
    logic signed [pdr_pkg::AMW-1:0] ang;
    logic signed [pdr_pkg::DW:0]    hsum;
    pdr_pkg::sat_t                  hsat;

    assign prod_f = vel_forward * $signed({1'b0, interval});
    assign prod_l = vel_lateral * $signed({1'b0, interval});
    assign prod_t = vel_turn * $signed({1'b0, interval});
    assign ang    = $signed({heading, 6'b0});
    assign hsum   = (pdr_pkg::DW + 1)'(fr_reg[0].hd) + (pdr_pkg::DW + 1)'(fr_reg[0].dth);
    assign hsat   = pdr_pkg::sat32(pdr_pkg::SAT_W'(hsum));

    always_comb
    begin
        fr_next[0]      = fr_reg[0];
        fr_next[0].px   = pose_x;
        fr_next[0].py   = pose_y;
        fr_next[0].hd   = heading;
        fr_next[0].dx   = prod_f[63:pdr_pkg::POS_FRAC_BITS];
        fr_next[0].dy   = prod_l[63:pdr_pkg::POS_FRAC_BITS];
        fr_next[0].dth  = prod_t[63:pdr_pkg::POS_FRAC_BITS];
        fr_next[0].asgn = ang[pdr_pkg::AMW-1];
        fr_next[0].amag = ang[pdr_pkg::AMW-1] ? pdr_pkg::AMW'(-ang) : pdr_pkg::AMW'(ang);

        fr_next[1]        = fr_reg[0];
        fr_next[1].amag   = pdr_pkg::mod_step(pdr_pkg::mod_step(fr_reg[0].amag, 4), 3);
        fr_next[1].hd_new = hsat.val;
        fr_next[1].hov    = hsat.ovf;

        fr_next[2]      = fr_reg[1];
        fr_next[2].amag = pdr_pkg::mod_step(pdr_pkg::mod_step(fr_reg[1].amag, 2), 1);

        fr_next[3]      = fr_reg[2];
        fr_next[3].amag = pdr_pkg::mod_step(fr_reg[2].amag, 0);

        // Truncating remainder keeps the sign of the dividend.
        fr_next[4]   = fr_reg[3];
        fr_next[4].r = fr_reg[3].asgn ? -$signed({3'b0, fr_reg[3].amag[32:0]})
                                      :  $signed({3'b0, fr_reg[3].amag[32:0]});

        fr_next[5] = fr_reg[4];
        if (fr_reg[4].r > pdr_pkg::PI_A)
        begin
            fr_next[5].r = fr_reg[4].r - pdr_pkg::TWO_PI_A;
        end
        else if (fr_reg[4].r < -pdr_pkg::PI_A)
        begin
            fr_next[5].r = fr_reg[4].r + pdr_pkg::TWO_PI_A;
        end

        // Outside the right half plane, turn by pi and negate the results later.
        fr_next[6]     = fr_reg[5];
        fr_next[6].neg = 1'b0;
        if (fr_reg[5].r > pdr_pkg::HALF_PI_A)
        begin
            fr_next[6].r   = fr_reg[5].r - pdr_pkg::PI_A;
            fr_next[6].neg = 1'b1;
        end
        else if (fr_reg[5].r < -pdr_pkg::HALF_PI_A)
        begin
            fr_next[6].r   = fr_reg[5].r + pdr_pkg::PI_A;
            fr_next[6].neg = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < pdr_pkg::FR_N; k++)
            begin
                fr_vld_reg[k] <= 1'b0;
            end
        end
        else
        begin
            fr_vld_reg[0] <= start;
            for (int k = 1; k < pdr_pkg::FR_N; k++)
            begin
                fr_vld_reg[k] <= fr_vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < pdr_pkg::FR_N; k++)
        begin
            fr_reg[k] <= fr_next[k];
        end
    end

    // ------------------------------------------------------------------
    // CORDIC chain.
    // ------------------------------------------------------------------
    pdr_pkg::side_t ci_side;
    pdr_pkg::cord_t ci_cord;
    logic           co_vld;
    pdr_pkg::side_t co_side;
    pdr_pkg::cord_t co_cord;

    assign ci_side.px     = fr_reg[pdr_pkg::FR_N-1].px;
    assign ci_side.py     = fr_reg[pdr_pkg::FR_N-1].py;
    assign ci_side.hd_new = fr_reg[pdr_pkg::FR_N-1].hd_new;
    assign ci_side.hov    = fr_reg[pdr_pkg::FR_N-1].hov;
    assign ci_side.dx     = fr_reg[pdr_pkg::FR_N-1].dx;
    assign ci_side.dy     = fr_reg[pdr_pkg::FR_N-1].dy;
    assign ci_side.neg    = fr_reg[pdr_pkg::FR_N-1].neg;
    assign ci_cord.x      = pdr_pkg::GAIN;
    assign ci_cord.y      = '0;
    assign ci_cord.z      = fr_reg[pdr_pkg::FR_N-1].r[pdr_pkg::CW-1:0];

    pdr_cordic u_cordic
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (fr_vld_reg[pdr_pkg::FR_N-1]),
        .in_side  (ci_side),
        .in_cord  (ci_cord),
        .out_vld  (co_vld),
        .out_side (co_side),
        .out_cord (co_cord)
    );

    // ------------------------------------------------------------------
    // Back end: sign fix, partial products, combine, sum, saturate.
    // ------------------------------------------------------------------
    logic                              c0_vld_reg, c1_vld_reg, c2_vld_reg, c3_vld_reg;
    pdr_pkg::side_t                    c0_side_reg, c1_side_reg, c2_side_reg, c3_side_reg;
    logic signed [pdr_pkg::CW-1:0]     cs_reg, sn_reg;
    logic signed [pdr_pkg::HW+pdr_pkg::CW-1:0] hxc_reg, hys_reg, hyc_reg, hxs_reg;
    logic signed [pdr_pkg::CW+24:0]    lxc_reg, lys_reg, lyc_reg, lxs_reg;
    logic signed [pdr_pkg::MW-1:0]     mxc_reg, mys_reg, myc_reg, mxs_reg;
    logic signed [pdr_pkg::SAT_W-1:0]  sx_reg, sy_reg;

    logic signed [pdr_pkg::HW-1:0]     hx, hy;
    logic signed [24:0]                lx, ly;
    logic signed [pdr_pkg::FW-1:0]     fxc, fys, fyc, fxs;
    logic signed [pdr_pkg::SAT_W-1:0]  sx_next, sy_next;
    pdr_pkg::sat_t                     satx, saty;

    assign hx = c0_side_reg.dx[pdr_pkg::DW-1:24];
    assign hy = c0_side_reg.dy[pdr_pkg::DW-1:24];
    assign lx = $signed({1'b0, c0_side_reg.dx[23:0]});
    assign ly = $signed({1'b0, c0_side_reg.dy[23:0]});

    // Reassemble d * t from the high and low partial products.
    assign fxc = pdr_pkg::FW'($signed({hxc_reg, 24'b0})) + pdr_pkg::FW'(lxc_reg);
    assign fys = pdr_pkg::FW'($signed({hys_reg, 24'b0})) + pdr_pkg::FW'(lys_reg);
    assign fyc = pdr_pkg::FW'($signed({hyc_reg, 24'b0})) + pdr_pkg::FW'(lyc_reg);
    assign fxs = pdr_pkg::FW'($signed({hxs_reg, 24'b0})) + pdr_pkg::FW'(lxs_reg);

    assign sx_next = pdr_pkg::SAT_W'(c2_side_reg.px) + pdr_pkg::SAT_W'(mxc_reg)
                   - pdr_pkg::SAT_W'(mys_reg);
    assign sy_next = pdr_pkg::SAT_W'(c2_side_reg.py) + pdr_pkg::SAT_W'(myc_reg)
                   + pdr_pkg::SAT_W'(mxs_reg);

    assign satx = pdr_pkg::sat32(sx_reg);
    assign saty = pdr_pkg::sat32(sy_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c0_vld_reg <= 1'b0;
            c1_vld_reg <= 1'b0;
            c2_vld_reg <= 1'b0;
            c3_vld_reg <= 1'b0;
            done       <= 1'b0;
        end
        else
        begin
            c0_vld_reg <= co_vld;
            c1_vld_reg <= c0_vld_reg;
            c2_vld_reg <= c1_vld_reg;
            c3_vld_reg <= c2_vld_reg;
            done       <= c3_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        c0_side_reg <= co_side;
        cs_reg      <= co_side.neg ? -co_cord.x : co_cord.x;
        sn_reg      <= co_side.neg ? -co_cord.y : co_cord.y;

        c1_side_reg <= c0_side_reg;
        hxc_reg     <= hx * cs_reg;
        lxc_reg     <= lx * cs_reg;
        hys_reg     <= hy * sn_reg;
        lys_reg     <= ly * sn_reg;
        hyc_reg     <= hy * cs_reg;
        lyc_reg     <= ly * cs_reg;
        hxs_reg     <= hx * sn_reg;
        lxs_reg     <= lx * sn_reg;

        c2_side_reg <= c1_side_reg;
        mxc_reg     <= fxc[pdr_pkg::FW-1:30];
        mys_reg     <= fys[pdr_pkg::FW-1:30];
        myc_reg     <= fyc[pdr_pkg::FW-1:30];
        mxs_reg     <= fxs[pdr_pkg::FW-1:30];

        c3_side_reg <= c2_side_reg;
        sx_reg      <= sx_next;
        sy_reg      <= sy_next;

        new_x       <= satx.val;
        new_y       <= saty.val;
        new_heading <= c3_side_reg.hd_new;
        overflow    <= satx.ovf | saty.ovf | c3_side_reg.hov;
    end

    // ------------------------------------------------------------------
    // Checks.
    // ------------------------------------------------------------------
    `PDR_ASSERT_IMPL(a_ovf_rail, clk, rst_n, done && overflow,
        new_x == pdr_pkg::S32_MAX || new_x == pdr_pkg::S32_MIN ||
        new_y == pdr_pkg::S32_MAX || new_y == pdr_pkg::S32_MIN ||
        new_heading == pdr_pkg::S32_MAX || new_heading == pdr_pkg::S32_MIN)
    `PDR_ASSERT_IMPL(a_angle_range, clk, rst_n, fr_vld_reg[pdr_pkg::FR_N-1],
        fr_reg[pdr_pkg::FR_N-1].r <= pdr_pkg::HALF_PI_A &&
        fr_reg[pdr_pkg::FR_N-1].r >= -pdr_pkg::HALF_PI_A)
    `PDR_ASSERT_NEXT(a_back_valid, clk, rst_n, co_vld, c0_vld_reg)

endmodule
